### design/otci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package otci_pkg;

	// Line scanner modes
	localparam logic [2:0] MODE_TOP     = 3'd0;
	localparam logic [2:0] MODE_SKIP    = 3'd1;
	localparam logic [2:0] MODE_KW_M    = 3'd2;
	localparam logic [2:0] MODE_KW_U    = 3'd3;
	localparam logic [2:0] MODE_F_SPACE = 3'd4;
	localparam logic [2:0] MODE_V_KIND  = 3'd5;
	localparam logic [2:0] MODE_FACE    = 3'd6;
	localparam logic [2:0] MODE_ERROR   = 3'd7;

	// Result kinds
	localparam logic [1:0] KIND_RECORD  = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Command types
	localparam logic [1:0] TYPE_VERTEX   = 2'd0;
	localparam logic [1:0] TYPE_TEXCOORD = 2'd1;
	localparam logic [1:0] TYPE_NORMAL   = 2'd2;
	localparam logic [1:0] TYPE_FACE     = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_OK          = 3'd0;
	localparam logic [2:0] ERR_BAD_START   = 3'd1;
	localparam logic [2:0] ERR_BAD_KEYWORD = 3'd2;
	localparam logic [2:0] ERR_F_NO_SPACE  = 3'd3;
	localparam logic [2:0] ERR_BAD_V_KIND  = 3'd4;
	localparam logic [2:0] ERR_BAD_FACE    = 3'd5;
	localparam logic [2:0] ERR_TABLE_FULL  = 3'd6;

	// Keyword length (mtllib and usemtl are both six letters)
	localparam logic [2:0] KW_LEN = 3'd6;

	// Saturation limits of the fixed-width counters
	localparam logic [23:0] MAX24 = 24'hFF_FFFF;
	localparam logic [15:0] MAX16 = 16'hFFFF;

	// Letters of the two skipped keywords, indexed by position
	function automatic logic [7:0] kw_char(input logic is_u, input logic [2:0] step);
		logic [7:0] ch;
		ch = 8'h00;
		unique case (step)
			3'd0: ch = is_u ? "u" : "m";
			3'd1: ch = is_u ? "s" : "t";
			3'd2: ch = is_u ? "e" : "l";
			3'd3: ch = is_u ? "m" : "l";
			3'd4: ch = is_u ? "t" : "i";
			3'd5: ch = is_u ? "l" : "b";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  ctype;
		logic [2:0]  err;
	} res_ctl_t;

endpackage

`default_nettype wire

### design/obj_text_command_indexer.sv
// Flow: a taken byte is scanned in the input register, and its result, if any, is written
// into the result register and offered from there.
// Throughput: one byte per cycle; the input stalls only while the scanned byte has a result
// and the result register still holds one that is not being taken.
// Reset (arst_n low, asynchronous): both registers empty, scanner at line start, counters
// zero, first-command table all ones. A zero byte emits the summary and rearms likewise.
`timescale 1ns / 1ps
`default_nettype none

module obj_text_command_indexer
	import otci_pkg::*;
#(
	parameter int OFFSET_BITS  = 24,
	parameter int COMMAND_BITS = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,

	input  wire                     text_valid,
	output logic                    text_ready,
	input  wire  [7:0]              text_char,

	output logic                    result_valid,
	input  wire                     result_ready,
	output logic [1:0]              result_kind,
	output logic [1:0]              command_type,
	output logic [COMMAND_BITS-1:0] command_number,
	output logic [OFFSET_BITS-1:0]  text_offset,
	output logic [23:0]             newline_count,
	output logic [15:0]             face_count,
	output logic [23:0]             triangle_total,
	output logic [COMMAND_BITS-1:0] first_face,
	output logic [COMMAND_BITS-1:0] first_vertex,
	output logic [COMMAND_BITS-1:0] first_texcoord,
	output logic [COMMAND_BITS-1:0] first_normal,
	output logic [2:0]              error_code
);

	// A command number of all ones marks an empty entry of the first-command table.
	localparam logic [COMMAND_BITS-1:0] CMD_NONE = {COMMAND_BITS{1'b1}};
	localparam logic [COMMAND_BITS-1:0] CMD_ONE  = {{(COMMAND_BITS-1){1'b0}}, 1'b1};
	localparam logic [OFFSET_BITS-1:0]  POS_ONE  = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

	// Input register: the byte being scanned this cycle.
	logic        valid_s1;
	logic [7:0]  char_s1;

	// Scanner state
	logic [2:0]              mode_q;
	logic [2:0]              kw_step_q;
	logic [OFFSET_BITS-1:0]  pos_q;
	logic [COMMAND_BITS-1:0] cmd_q;
	logic [23:0]             nl_q;
	logic [15:0]             face_q;
	logic [23:0]             tri_q;
	logic [15:0]             tok_q;
	logic                    in_tok_q;
	logic [COMMAND_BITS-1:0] first_q [4];
	logic [OFFSET_BITS-1:0]  held_q;
	logic [2:0]              err_q;

	// Next values after the current byte
	logic [2:0]              mode_d;
	logic [2:0]              kw_step_d;
	logic [COMMAND_BITS-1:0] cmd_d;
	logic [23:0]             nl_d;
	logic [15:0]             face_d;
	logic [23:0]             tri_d;
	logic [15:0]             tok_d;
	logic                    in_tok_d;
	logic [COMMAND_BITS-1:0] first_d [4];
	logic [OFFSET_BITS-1:0]  held_d;
	logic [2:0]              err_d;
	logic                    rearm;

	// Result of the current byte
	logic                    res_valid;
	res_ctl_t                res_ctl;
	logic [COMMAND_BITS-1:0] res_num;
	logic [OFFSET_BITS-1:0]  res_off;

	logic advance;

	// Character classes
	logic is_nl, is_sp, is_dig;
	assign is_nl  = (char_s1 == 8'h0D) || (char_s1 == 8'h0A);
	assign is_sp  = (char_s1 == " ") || (char_s1 == 8'h09);
	assign is_dig = ((char_s1 >= "0") && (char_s1 <= "9")) || (char_s1 == "/");

	// Closing a face line: count a token still open, then add tokens minus two to the
	// triangle total when there are at least three, saturating at the top.
	logic [15:0] tok_fin;
	logic [15:0] tri_add;
	logic [24:0] tri_sum;
	logic [23:0] tri_fin;
	assign tok_fin = (in_tok_q && (tok_q != MAX16)) ? tok_q + 16'd1 : tok_q;
	assign tri_add = tok_fin - 16'd2;
	assign tri_sum = {1'b0, tri_q} + {9'd0, tri_add};
	always_comb begin
		if (tok_fin < 16'd3) begin
			tri_fin = tri_q;
		end else if (tri_sum > {1'b0, MAX24}) begin
			tri_fin = MAX24;
		end else begin
			tri_fin = tri_sum[23:0];
		end
	end

	// Per-byte scanner step
	always_comb begin
		logic       fail_req;
		logic [2:0] fail_code;
		logic       rec_req;
		logic [1:0] rec_type;

		mode_d    = mode_q;
		kw_step_d = kw_step_q;
		cmd_d     = cmd_q;
		nl_d      = nl_q;
		face_d    = face_q;
		tri_d     = tri_q;
		tok_d     = tok_q;
		in_tok_d  = in_tok_q;
		first_d   = first_q;
		held_d    = held_q;
		err_d     = err_q;
		rearm     = 1'b0;
		res_valid = 1'b0;
		res_ctl   = '{kind: KIND_RECORD, ctype: TYPE_VERTEX, err: ERR_OK};
		res_num   = '0;
		res_off   = pos_q;
		fail_req  = 1'b0;
		fail_code = ERR_OK;
		rec_req   = 1'b0;
		rec_type  = TYPE_VERTEX;

		// Newlines are counted in every mode, even after an error.
		if (is_nl && (nl_q != MAX24)) begin
			nl_d = nl_q + 24'd1;
		end

		if (char_s1 == 8'h00) begin
			// End of text: summary, then back to the reset state.
			res_valid   = 1'b1;
			res_ctl.kind = KIND_SUMMARY;
			res_ctl.err  = err_q;
			rearm       = 1'b1;
			unique case (mode_q)
				MODE_FACE:            tri_d = tri_fin;
				MODE_KW_M, MODE_KW_U: res_ctl.err = ERR_BAD_KEYWORD;
				MODE_F_SPACE:         res_ctl.err = ERR_F_NO_SPACE;
				MODE_V_KIND:          res_ctl.err = ERR_BAD_V_KIND;
				default:              ;
			endcase
		end else begin
			unique case (mode_q)
				MODE_TOP: begin
					if (is_sp || is_nl) begin
						mode_d = MODE_TOP;
					end else if ((char_s1 == "#") || (char_s1 == "o") ||
					             (char_s1 == "g") || (char_s1 == "s")) begin
						mode_d = MODE_SKIP;
					end else if ((char_s1 == "m") || (char_s1 == "u")) begin
						mode_d    = (char_s1 == "m") ? MODE_KW_M : MODE_KW_U;
						kw_step_d = 3'd1;
					end else if ((char_s1 == "f") || (char_s1 == "v")) begin
						mode_d = (char_s1 == "f") ? MODE_F_SPACE : MODE_V_KIND;
						held_d = pos_q;
					end else begin
						fail_req  = 1'b1;
						fail_code = ERR_BAD_START;
					end
				end
				MODE_SKIP: begin
					if (is_nl) begin
						mode_d = MODE_TOP;
					end
				end
				MODE_KW_M, MODE_KW_U: begin
					if (kw_step_q < KW_LEN) begin
						if (char_s1 != kw_char(mode_q == MODE_KW_U, kw_step_q)) begin
							fail_req  = 1'b1;
							fail_code = ERR_BAD_KEYWORD;
						end else begin
							kw_step_d = kw_step_q + 3'd1;
						end
					end else if (!is_sp) begin
						fail_req  = 1'b1;
						fail_code = ERR_BAD_KEYWORD;
					end else begin
						kw_step_d = 3'd0;
						mode_d    = MODE_SKIP;
					end
				end
				MODE_F_SPACE: begin
					if (!is_sp) begin
						fail_req  = 1'b1;
						fail_code = ERR_F_NO_SPACE;
					end else begin
						tok_d    = '0;
						in_tok_d = 1'b0;
						mode_d   = MODE_FACE;
						rec_req  = 1'b1;
						rec_type = TYPE_FACE;
					end
				end
				MODE_V_KIND: begin
					if (is_sp || (char_s1 == "t") || (char_s1 == "n")) begin
						mode_d  = MODE_SKIP;
						rec_req = 1'b1;
						if (is_sp) begin
							rec_type = TYPE_VERTEX;
						end else if (char_s1 == "t") begin
							rec_type = TYPE_TEXCOORD;
						end else begin
							rec_type = TYPE_NORMAL;
						end
					end else begin
						fail_req  = 1'b1;
						fail_code = ERR_BAD_V_KIND;
					end
				end
				MODE_FACE: begin
					if (is_dig) begin
						in_tok_d = 1'b1;
					end else if (is_sp) begin
						if (in_tok_q && (tok_q != MAX16)) begin
							tok_d = tok_q + 16'd1;
						end
						in_tok_d = 1'b0;
					end else if (is_nl) begin
						tri_d    = tri_fin;
						tok_d    = '0;
						in_tok_d = 1'b0;
						mode_d   = MODE_TOP;
					end else begin
						fail_req  = 1'b1;
						fail_code = ERR_BAD_FACE;
					end
				end
				MODE_ERROR: ;
				default:    ;
			endcase

			// A command that would take the empty-entry number overflows the table.
			if (rec_req) begin
				if (cmd_q == CMD_NONE) begin
					fail_req  = 1'b1;
					fail_code = ERR_TABLE_FULL;
				end else begin
					if (first_q[rec_type] == CMD_NONE) begin
						first_d[rec_type] = cmd_q;
					end
					cmd_d = cmd_q + CMD_ONE;
					if ((rec_type == TYPE_FACE) && (face_q != MAX16)) begin
						face_d = face_q + 16'd1;
					end
					res_valid     = 1'b1;
					res_ctl.kind  = KIND_RECORD;
					res_ctl.ctype = rec_type;
					res_num       = cmd_q;
					res_off       = held_q;
				end
			end

			if (fail_req) begin
				err_d         = fail_code;
				mode_d        = MODE_ERROR;
				res_valid     = 1'b1;
				res_ctl.kind  = KIND_ERROR;
				res_ctl.ctype = TYPE_VERTEX;
				res_ctl.err   = fail_code;
				res_num       = '0;
				res_off       = pos_q;
			end
		end
	end

	// The byte in the input register moves on unless its result finds the result
	// register occupied and not being taken.
	assign advance    = valid_s1 && (!res_valid || !result_valid || result_ready);
	assign text_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			char_s1 <= text_char;
		end
	end

	// Scanner state update; a zero byte returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TOP;
			kw_step_q <= '0;
			pos_q     <= '0;
			cmd_q     <= '0;
			nl_q      <= '0;
			face_q    <= '0;
			tri_q     <= '0;
			tok_q     <= '0;
			in_tok_q  <= 1'b0;
			first_q   <= '{default: CMD_NONE};
			held_q    <= '0;
			err_q     <= ERR_OK;
		end else if (advance) begin
			if (rearm) begin
				mode_q    <= MODE_TOP;
				kw_step_q <= '0;
				pos_q     <= '0;
				cmd_q     <= '0;
				nl_q      <= '0;
				face_q    <= '0;
				tri_q     <= '0;
				tok_q     <= '0;
				in_tok_q  <= 1'b0;
				first_q   <= '{default: CMD_NONE};
				held_q    <= '0;
				err_q     <= ERR_OK;
			end else begin
				mode_q    <= mode_d;
				kw_step_q <= kw_step_d;
				pos_q     <= pos_q + POS_ONE;
				cmd_q     <= cmd_d;
				nl_q      <= nl_d;
				face_q    <= face_d;
				tri_q     <= tri_d;
				tok_q     <= tok_d;
				in_tok_q  <= in_tok_d;
				first_q   <= first_d;
				held_q    <= held_d;
				err_q     <= err_d;
			end
		end
	end

	// Result register: running values are those after the byte that caused the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && res_valid) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_kind    <= res_ctl.kind;
			command_type   <= res_ctl.ctype;
			error_code     <= res_ctl.err;
			command_number <= res_num;
			text_offset    <= res_off;
			newline_count  <= nl_d;
			face_count     <= face_d;
			triangle_total <= tri_d;
			first_vertex   <= first_d[TYPE_VERTEX];
			first_texcoord <= first_d[TYPE_TEXCOORD];
			first_normal   <= first_d[TYPE_NORMAL];
			first_face     <= first_d[TYPE_FACE];
		end
	end

	// A byte held in the input register is never lost or replaced while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1))
		else $error("input register changed while its byte was stalled");

	// Once an error has been recorded the scanner stays in its error mode until the end.
	assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ERR_OK |-> mode_q == MODE_ERROR)
		else $error("recorded error without error mode");

	// The end of text rearms the scanner.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (char_s1 == 8'h00) |=> mode_q == MODE_TOP && cmd_q == '0 && err_q == ERR_OK)
		else $error("scanner not rearmed after end of text");

	// Command records never carry an error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == KIND_RECORD) |-> error_code == ERR_OK)
		else $error("command record with error code");

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import otci_pkg::*;

	// Limits of the run. The watchdog limit is several times the slowest correct run,
	// with the longest gaps on both sides for every byte and the long hold-off.
	localparam int WATCHDOG_CYCLES = 400_000;
	localparam int RANDOM_BYTES    = 420;
	localparam int HOLD_CYCLES     = 300;
	localparam int DIR_ROWS        = 33;

	localparam logic [15:0] NO_CMD      = 16'hFFFF;
	localparam logic [47:0] WORD_MTLLIB = "mtllib";
	localparam logic [47:0] WORD_USEMTL = "usemtl";

	// One result item of the block, with the fields in port order.
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  ctype;
		logic [15:0] number;
		logic [23:0] offset;
		logic [23:0] newlines;
		logic [15:0] faces;
		logic [23:0] triangles;
		logic [15:0] first_f;
		logic [15:0] first_v;
		logic [15:0] first_t;
		logic [15:0] first_n;
		logic [2:0]  err;
	} scan_result_t;

	localparam scan_result_t NO_RESULT = '0;

	// A row of the directed stimulus. Where typed is set, want is the result that the row
	// must give; otherwise the scanner model decides.
	typedef struct packed {
		logic [7:0]   ch;
		logic         typed;
		scan_result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic [7:0]  text_char = 8'h00;
	logic        text_ready;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [1:0]  command_type;
	logic [15:0] command_number;
	logic [23:0] text_offset;
	logic [23:0] newline_count;
	logic [15:0] face_count;
	logic [23:0] triangle_total;
	logic [15:0] first_face;
	logic [15:0] first_vertex;
	logic [15:0] first_texcoord;
	logic [15:0] first_normal;
	logic [2:0]  error_code;

	obj_text_command_indexer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_valid    (text_valid),
		.text_ready    (text_ready),
		.text_char     (text_char),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_kind   (result_kind),
		.command_type  (command_type),
		.command_number(command_number),
		.text_offset   (text_offset),
		.newline_count (newline_count),
		.face_count    (face_count),
		.triangle_total(triangle_total),
		.first_face    (first_face),
		.first_vertex  (first_vertex),
		.first_texcoord(first_texcoord),
		.first_normal  (first_normal),
		.error_code    (error_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results that the scanner model says are still to come, oldest first.
	scan_result_t pending_results[$];
	int           mismatches = 0;
	int           cycle_count = 0;
	int           sent_bytes = 0;
	// While steady_flow is set neither side inserts gaps.
	bit           steady_flow = 1'b0;
	// Set by the stimulus to ask the result side for one long hold-off; cleared by the
	// result side as the hold-off begins.
	bit           hold_request = 1'b0;
	logic [7:0]   text_buf[$];
	stim_row_t    dir_rows [DIR_ROWS];

	// ------------------------------------------------------------------
	// Scanner model: its own copy of the line state and running counters.
	// ------------------------------------------------------------------
	logic [2:0]  scan_mode;
	logic [2:0]  kw_index;
	logic [23:0] byte_pos;
	logic [15:0] cmd_next;
	logic [23:0] nl_total;
	logic [15:0] face_total;
	logic [23:0] tri_total;
	logic [15:0] token_total;
	logic        token_open;
	logic [15:0] first_cmd [4];
	logic [23:0] line_offset;
	logic [2:0]  latched_err;

	// The state after reset, and after every zero byte.
	function automatic void rearm_scanner();
		scan_mode   = MODE_TOP;
		kw_index    = '0;
		byte_pos    = '0;
		cmd_next    = '0;
		nl_total    = '0;
		face_total  = '0;
		tri_total   = '0;
		token_total = '0;
		token_open  = 1'b0;
		for (int i = 0; i < 4; i++)
			first_cmd[i] = NO_CMD;
		line_offset = '0;
		latched_err = ERR_OK;
	endfunction

	// Every result carries the running counters as they stand after the byte.
	function automatic scan_result_t pack_result(input logic [1:0] kind, input logic [1:0] ctype,
			input logic [15:0] number, input logic [23:0] offset, input logic [2:0] err);
		scan_result_t r;
		r.kind      = kind;
		r.ctype     = ctype;
		r.number    = number;
		r.offset    = offset;
		r.newlines  = nl_total;
		r.faces     = face_total;
		r.triangles = tri_total;
		r.first_f   = first_cmd[TYPE_FACE];
		r.first_v   = first_cmd[TYPE_VERTEX];
		r.first_t   = first_cmd[TYPE_TEXCOORD];
		r.first_n   = first_cmd[TYPE_NORMAL];
		r.err       = err;
		return r;
	endfunction

	// A face line closes: a token still open counts, and tokens beyond the second each add
	// one triangle, with the total held at its maximum.
	function automatic void close_face();
		logic [15:0] n;
		logic [23:0] add;
		n = token_total;
		if (token_open && n != 16'hFFFF)
			n = n + 16'd1;
		if (n >= 16'd3) begin
			add = {8'h00, n - 16'd2};
			if (tri_total > 24'hFF_FFFF - add)
				tri_total = 24'hFF_FFFF;
			else
				tri_total = tri_total + add;
		end
		token_total = '0;
		token_open  = 1'b0;
	endfunction

	// The first error is reported once; the scanner then ignores the rest of the text but for its newlines.
	function automatic scan_result_t raise_error(input logic [2:0] code, input logic [23:0] pos);
		latched_err = code;
		scan_mode   = MODE_ERROR;
		return pack_result(KIND_ERROR, 2'd0, 16'd0, pos, code);
	endfunction

	function automatic scan_result_t log_command(input logic [1:0] ctype, input logic [23:0] pos);
		logic [15:0] num;
		// The all-ones number means "none", so a command that would take it cannot be kept.
		if (cmd_next == NO_CMD)
			return raise_error(ERR_TABLE_FULL, pos);
		num = cmd_next;
		if (first_cmd[ctype] == NO_CMD)
			first_cmd[ctype] = num;
		cmd_next = num + 16'd1;
		if (ctype == TYPE_FACE && face_total != 16'hFFFF)
			face_total = face_total + 16'd1;
		return pack_result(KIND_RECORD, ctype, num, line_offset, ERR_OK);
	endfunction

	// Advances the model by one byte; returns 1 when the byte gives a result.
	function automatic bit scan_byte(input logic [7:0] c, output scan_result_t res);
		logic [23:0] pos;
		logic [2:0]  err;
		logic [1:0]  vkind;
		logic [47:0] word;
		logic [7:0]  want_ch;
		bit          is_nl;
		bit          is_sp;
		bit          is_tok;
		pos    = byte_pos;
		byte_pos = byte_pos + 24'd1;
		is_nl  = (c == 8'h0D || c == 8'h0A);
		is_sp  = (c == " " || c == 8'h09);
		is_tok = (c >= "0" && c <= "9") || c == "/";
		res    = NO_RESULT;
		if (is_nl && nl_total != 24'hFF_FFFF)
			nl_total = nl_total + 24'd1;

		// The zero byte ends the text. A line cut short in a keyword, after a lone f or
		// after a lone v shows up only in the summary's error code.
		if (c == 8'h00) begin
			err = latched_err;
			case (scan_mode)
				MODE_FACE: close_face();
				MODE_KW_M, MODE_KW_U: err = ERR_BAD_KEYWORD;
				MODE_F_SPACE: err = ERR_F_NO_SPACE;
				MODE_V_KIND: err = ERR_BAD_V_KIND;
				default: ;
			endcase
			res = pack_result(KIND_SUMMARY, 2'd0, 16'd0, pos, err);
			rearm_scanner();
			return 1'b1;
		end

		case (scan_mode)
			MODE_TOP: begin
				if (is_sp || is_nl)
					return 1'b0;
				if (c == "#" || c == "o" || c == "g" || c == "s") begin
					scan_mode = MODE_SKIP;
					return 1'b0;
				end
				if (c == "m" || c == "u") begin
					scan_mode = (c == "m") ? MODE_KW_M : MODE_KW_U;
					kw_index  = 3'd1;
					return 1'b0;
				end
				if (c == "f" || c == "v") begin
					scan_mode   = (c == "f") ? MODE_F_SPACE : MODE_V_KIND;
					line_offset = pos;
					return 1'b0;
				end
				res = raise_error(ERR_BAD_START, pos);
				return 1'b1;
			end
			MODE_SKIP: begin
				if (is_nl)
					scan_mode = MODE_TOP;
				return 1'b0;
			end
			MODE_KW_M, MODE_KW_U: begin
				word = (scan_mode == MODE_KW_M) ? WORD_MTLLIB : WORD_USEMTL;
				if (kw_index < KW_LEN) begin
					want_ch = word[47 - 8 * kw_index -: 8];
					if (c != want_ch) begin
						res = raise_error(ERR_BAD_KEYWORD, pos);
						return 1'b1;
					end
					kw_index = kw_index + 3'd1;
					return 1'b0;
				end
				// The whole keyword has been seen; it must be followed by blank space.
				if (!is_sp) begin
					res = raise_error(ERR_BAD_KEYWORD, pos);
					return 1'b1;
				end
				kw_index  = '0;
				scan_mode = MODE_SKIP;
				return 1'b0;
			end
			MODE_F_SPACE: begin
				if (!is_sp) begin
					res = raise_error(ERR_F_NO_SPACE, pos);
					return 1'b1;
				end
				token_total = '0;
				token_open  = 1'b0;
				scan_mode   = MODE_FACE;
				res = log_command(TYPE_FACE, pos);
				return 1'b1;
			end
			MODE_V_KIND: begin
				if (is_sp)
					vkind = TYPE_VERTEX;
				else if (c == "t")
					vkind = TYPE_TEXCOORD;
				else if (c == "n")
					vkind = TYPE_NORMAL;
				else begin
					res = raise_error(ERR_BAD_V_KIND, pos);
					return 1'b1;
				end
				scan_mode = MODE_SKIP;
				res = log_command(vkind, pos);
				return 1'b1;
			end
			MODE_FACE: begin
				if (is_tok) begin
					token_open = 1'b1;
					return 1'b0;
				end
				if (is_sp) begin
					if (token_open && token_total != 16'hFFFF)
						token_total = token_total + 16'd1;
					token_open = 1'b0;
					return 1'b0;
				end
				if (is_nl) begin
					close_face();
					scan_mode = MODE_TOP;
					return 1'b0;
				end
				res = raise_error(ERR_BAD_FACE, pos);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Random text
	// ------------------------------------------------------------------

	// Most gaps are absent or short, a few are long.
	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] sep_char();
		return $urandom_range(0, 1) ? 8'h20 : 8'h09;
	endfunction

	function automatic logic [7:0] token_char();
		int r;
		r = $urandom_range(0, 10);
		return (r == 10) ? 8'h2F : 8'(8'h30 + r);
	endfunction

	// Any byte that neither ends a line nor ends the text.
	function automatic logic [7:0] skip_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == 8'h0A || c == 8'h0D);
		return c;
	endfunction

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic push_eol();
		case ($urandom_range(0, 2))
			0: text_buf.push_back(8'h0A);
			1: begin
				text_buf.push_back(8'h0D);
				text_buf.push_back(8'h0A);
			end
			default: text_buf.push_back(8'h0D);
		endcase
	endtask

	// A face line without its line end. With stray set, one token is followed by a
	// random byte, which is usually one that a face line does not allow.
	task automatic push_face(input int n_tok, input bit stray);
		int stray_at;
		stray_at = (stray && n_tok > 0) ? $urandom_range(0, n_tok - 1) : -1;
		text_buf.push_back("f");
		text_buf.push_back(sep_char());
		for (int i = 0; i < n_tok; i++) begin
			repeat ($urandom_range(1, 4))
				text_buf.push_back(token_char());
			if (i == stray_at)
				text_buf.push_back(8'($urandom_range(1, 255)));
			if (i < n_tok - 1 || $urandom_range(0, 1))
				repeat ($urandom_range(1, 2))
					text_buf.push_back(sep_char());
		end
	endtask

	// One text: a few lines, mostly well formed, ended by a zero byte.
	task automatic build_text();
		int    kind;
		int    k;
		string word;
		text_buf.delete();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					text_buf.push_back(sep_char());
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				text_buf.push_back("v");
				case ($urandom_range(0, 2))
					0: text_buf.push_back(sep_char());
					1: text_buf.push_back("t");
					default: text_buf.push_back("n");
				endcase
				repeat ($urandom_range(0, 10))
					text_buf.push_back($urandom_range(0, 2) ? token_char() : skip_byte());
				push_eol();
			end else if (kind < 45) begin
				push_face(($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
						: $urandom_range(0, 6), 1'b0);
				push_eol();
			end else if (kind < 57) begin
				case ($urandom_range(0, 3))
					0: text_buf.push_back("#");
					1: text_buf.push_back("o");
					2: text_buf.push_back("g");
					default: text_buf.push_back("s");
				endcase
				repeat ($urandom_range(0, 8))
					text_buf.push_back(skip_byte());
				push_eol();
			end else if (kind < 67) begin
				push_str($urandom_range(0, 1) ? "mtllib" : "usemtl");
				text_buf.push_back(sep_char());
				repeat ($urandom_range(1, 6))
					text_buf.push_back(skip_byte());
				push_eol();
			end else if (kind < 73) begin
				push_eol();
			end else begin
				// Broken lines of every sort.
				case ($urandom_range(0, 4))
					0: text_buf.push_back(8'($urandom_range(1, 255)));
					1: begin
						word = $urandom_range(0, 1) ? "mtllib" : "usemtl";
						k = $urandom_range(1, 6);
						push_str(word.substr(0, k - 1));
						text_buf.push_back(8'($urandom_range(1, 255)));
					end
					2: begin
						text_buf.push_back("f");
						text_buf.push_back(8'($urandom_range(1, 255)));
					end
					3: begin
						text_buf.push_back("v");
						text_buf.push_back(8'($urandom_range(1, 255)));
					end
					default: push_face($urandom_range(1, 5), 1'b1);
				endcase
				push_eol();
			end
		end
		// Now and then the text stops in the middle of a line.
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 3))
				0: push_face($urandom_range(0, 5), 1'b0);
				1: push_str("v");
				2: push_str("f");
				default: push_str("usem");
			endcase
		end
		text_buf.push_back(8'h00);
	endtask

	// ------------------------------------------------------------------
	// Text side
	// ------------------------------------------------------------------

	// Offers one byte and holds it until it is taken. The model is advanced at the edge
	// that takes the byte. A typed row supplies its own expected result.
	task automatic offer_byte(input logic [7:0] ch, input logic typed, input scan_result_t want);
		scan_result_t predicted;
		bit           gives_result;
		int           gap;
		text_char  <= ch;
		text_valid <= 1'b1;
		do
			@(posedge clk);
		while (!text_ready);
		sent_bytes++;
		gives_result = scan_byte(ch, predicted);
		if (typed)
			pending_results.push_back(want);
		else if (gives_result)
			pending_results.push_back(predicted);
		gap = pick_gap();
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits for every outstanding result, plus the pipeline depth.
	task automatic settle_results();
		text_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Ready is dropped for random stretches, and once for a long hold-off on request so
	// that both internal registers fill and the text side is stalled.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	function automatic void check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Every taken result is matched against the oldest expectation.
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: kind %0d, offset %0d",
					result_kind, text_offset);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", 24'(want.kind), 24'(result_kind));
				check_field("command_type", 24'(want.ctype), 24'(command_type));
				check_field("command_number", 24'(want.number), 24'(command_number));
				check_field("text_offset", want.offset, text_offset);
				check_field("newline_count", want.newlines, newline_count);
				check_field("face_count", 24'(want.faces), 24'(face_count));
				check_field("triangle_total", want.triangles, triangle_total);
				check_field("first_face", 24'(want.first_f), 24'(first_face));
				check_field("first_vertex", 24'(want.first_v), 24'(first_vertex));
				check_field("first_texcoord", 24'(want.first_t), 24'(first_texcoord));
				check_field("first_normal", 24'(want.first_n), 24'(first_normal));
				check_field("error_code", 24'(want.err), 24'(error_code));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > WATCHDOG_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		rearm_scanner();

		// Directed text. It covers a vertex and a face record, tokens split by spaces
		// and tabs, both line ends, a comment holding the all-ones byte, a bad line
		// start, a text cut off inside a keyword and after a lone v, an f not followed by
		// blank space, and a stray character in a face line.
		dir_rows = '{
			'{"v", 1'b0, NO_RESULT},
			'{" ", 1'b1, '{KIND_RECORD, TYPE_VERTEX, 16'd0, 24'd0, 24'd0, 16'd0, 24'd0,
				NO_CMD, 16'd0, NO_CMD, NO_CMD, ERR_OK}},
			'{8'h0A, 1'b0, NO_RESULT},
			'{"f", 1'b0, NO_RESULT},
			'{" ", 1'b0, NO_RESULT},
			'{"1", 1'b0, NO_RESULT},
			'{"/", 1'b0, NO_RESULT},
			'{" ", 1'b0, NO_RESULT},
			'{"2", 1'b0, NO_RESULT},
			'{8'h09, 1'b0, NO_RESULT},
			'{"3", 1'b0, NO_RESULT},
			'{"/", 1'b0, NO_RESULT},
			'{"9", 1'b0, NO_RESULT},
			'{8'h0D, 1'b0, NO_RESULT},
			'{8'h0A, 1'b0, NO_RESULT},
			'{"#", 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, NO_RESULT},
			'{8'h0A, 1'b0, NO_RESULT},
			'{"x", 1'b1, '{KIND_ERROR, 2'd0, 16'd0, 24'd18, 24'd4, 16'd1, 24'd1,
				16'd1, 16'd0, NO_CMD, NO_CMD, ERR_BAD_START}},
			'{8'h00, 1'b1, '{KIND_SUMMARY, 2'd0, 16'd0, 24'd19, 24'd4, 16'd1, 24'd1,
				16'd1, 16'd0, NO_CMD, NO_CMD, ERR_BAD_START}},
			'{"m", 1'b0, NO_RESULT},
			'{"t", 1'b0, NO_RESULT},
			'{8'h00, 1'b1, '{KIND_SUMMARY, 2'd0, 16'd0, 24'd2, 24'd0, 16'd0, 24'd0,
				NO_CMD, NO_CMD, NO_CMD, NO_CMD, ERR_BAD_KEYWORD}},
			'{"f", 1'b0, NO_RESULT},
			'{"x", 1'b1, '{KIND_ERROR, 2'd0, 16'd0, 24'd1, 24'd0, 16'd0, 24'd0,
				NO_CMD, NO_CMD, NO_CMD, NO_CMD, ERR_F_NO_SPACE}},
			'{8'h00, 1'b1, '{KIND_SUMMARY, 2'd0, 16'd0, 24'd2, 24'd0, 16'd0, 24'd0,
				NO_CMD, NO_CMD, NO_CMD, NO_CMD, ERR_F_NO_SPACE}},
			'{"v", 1'b0, NO_RESULT},
			'{8'h00, 1'b1, '{KIND_SUMMARY, 2'd0, 16'd0, 24'd1, 24'd0, 16'd0, 24'd0,
				NO_CMD, NO_CMD, NO_CMD, NO_CMD, ERR_BAD_V_KIND}},
			'{"f", 1'b0, NO_RESULT},
			'{8'h09, 1'b0, NO_RESULT},
			'{"1", 1'b0, NO_RESULT},
			'{"a", 1'b1, '{KIND_ERROR, 2'd0, 16'd0, 24'd3, 24'd0, 16'd1, 24'd0,
				16'd0, NO_CMD, NO_CMD, NO_CMD, ERR_BAD_FACE}},
			'{8'h00, 1'b0, NO_RESULT}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			offer_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
		// The text side pauses here until every result has come back.
		settle_results();

		// Back-pressure: a burst of texcoord lines at full rate while the result side
		// holds off, so the block fills up and stops taking bytes.
		steady_flow = 1'b1;
		hold_request = 1'b1;
		wait (!hold_request);
		repeat (30) begin
			offer_byte("v", 1'b0, NO_RESULT);
			offer_byte("t", 1'b0, NO_RESULT);
			offer_byte(8'h0A, 1'b0, NO_RESULT);
		end
		offer_byte(8'h00, 1'b0, NO_RESULT);
		steady_flow = 1'b0;
		settle_results();

		// Random texts, whole texts until the byte budget is spent.
		sent_bytes = 0;
		while (sent_bytes < RANDOM_BYTES) begin
			steady_flow = ($urandom_range(0, 5) == 0);
			build_text();
			foreach (text_buf[j])
				offer_byte(text_buf[j], 1'b0, NO_RESULT);
		end
		steady_flow = 1'b0;
		settle_results();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
design/otci_pkg.sv
design/obj_text_command_indexer.sv
bench/tb_top.sv
